// ----- design/gtg_pkg.sv -----
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Payload structs, controller states, register indexes and CORDIC tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;
  } gtg_in_t;

  typedef struct packed {
    logic [30:0]        linear_velocity;
    logic signed [31:0] angular_velocity;
    logic [6:0]         progress_percent;
    logic               goal_reached;
    logic               goal_active;
  } gtg_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_MUL0, S_MUL1, S_DIST, S_WRAP, S_MULA, S_MULB, S_FIN, S_DIV, S_OUT
  } gtg_state_t;

  typedef struct packed {
    logic goal_wr;
    logic load;
    logic rot;
    logic mul0;
    logic mul1;
    logic dist_ld;
    logic wrap;
    logic mula;
    logic mulb;
    logic fin;
    logic div;
    logic out_load;
  } gtg_cmd_t;

  typedef struct packed {
    logic armed;
    logic div_needed;
  } gtg_stat_t;

  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] REG_DIST_THR   = 3'd0;
  localparam logic [2:0] REG_ORIENT_THR = 3'd1;
  localparam logic [2:0] REG_LIN_GAIN   = 3'd2;
  localparam logic [2:0] REG_HEAD_GAIN  = 3'd3;
  localparam logic [2:0] REG_ORIENT_GAIN = 3'd4;

  localparam int ANG_PI     = 52707179;
  localparam int ANG_2PI    = 105414358;
  localparam logic [19:0] KINV_Q20 = 20'd636751;
  localparam int WRAP_STEPS = 6;
  localparam int DIV_STEPS  = 7;
  localparam logic [6:0] PROG_FULL = 7'd100;

  // Arctangent of 2^-i in units of 2^-24 rad.
  function automatic logic [24:0] atan_step(input logic [4:0] i);
    logic [24:0] r;
    r = '0;
    unique case (i)
      5'd0: r = 25'd13176795;
      5'd1: r = 25'd7778716;
      5'd2: r = 25'd4110060;
      5'd3: r = 25'd2086331;
      5'd4: r = 25'd1047214;
      5'd5: r = 25'd524117;
      5'd6: r = 25'd262123;
      5'd7: r = 25'd131069;
      5'd8: r = 25'd65536;
      default: begin
        if (i <= 5'd24) r = 25'd1 << (5'd24 - i);
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/go_to_goal_p_controller.sv -----
// Sequence: an idle tick goes straight to the output state; an armed tick walks the
// CORDIC steps, scaling, wrapping, gains and, when progress needs it, the divider.
// Throughput: one item at a time, the next accepted once the controller is idle again
// after the result is loaded; a goal write leaves the controller idle.
// Reset: synchronous active-low rst_n disarms the controller and restores the
// default thresholds and gains.
// ----------------------------------------------------------------------------
// go_to_goal_p_controller: planar go-to-goal proportional controller
// APB register file, sequencer and datapath of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_p_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire gtg_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output gtg_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(CORDIC_STEPS);

  logic [30:0] dist_thr_r;
  logic [13:0] orient_thr_r;
  logic [15:0] lin_gain_r, head_gain_r, orient_gain_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_thr_r    <= 31'd6554;
      orient_thr_r  <= 14'd410;
      lin_gain_r    <= 16'd256;
      head_gain_r   <= 16'd256;
      orient_gain_r <= 16'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIST_THR:    dist_thr_r    <= pwdata[30:0];
        REG_ORIENT_THR:  orient_thr_r  <= pwdata[13:0];
        REG_LIN_GAIN:    lin_gain_r    <= pwdata[15:0];
        REG_HEAD_GAIN:   head_gain_r   <= pwdata[15:0];
        REG_ORIENT_GAIN: orient_gain_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIST_THR:    prdata = {1'b0, dist_thr_r};
      REG_ORIENT_THR:  prdata = {18'd0, orient_thr_r};
      REG_LIN_GAIN:    prdata = {16'd0, lin_gain_r};
      REG_HEAD_GAIN:   prdata = {16'd0, head_gain_r};
      REG_ORIENT_GAIN: prdata = {16'd0, orient_gain_r};
      default:         prdata = '0;
    endcase
  end

  gtg_cmd_t      cmd;
  gtg_stat_t     stat;
  logic [CW-1:0] step;

  gtg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .step      (step)
  );

  gtg_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .CW(CW)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .step        (step),
    .in_data     (in_data),
    .dist_thr    (dist_thr_r),
    .orient_thr  (orient_thr_r),
    .lin_gain    (lin_gain_r),
    .head_gain   (head_gain_r),
    .orient_gain (orient_gain_r),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- design/gtg_datapath.sv -----
// ----------------------------------------------------------------------------
// gtg_datapath: arithmetic and state of the go-to-goal controller
// CORDIC vectoring, distance scaling, angle wrapping, P-control and progress.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_datapath
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int CW = $clog2(CORDIC_STEPS)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire gtg_cmd_t    cmd,
  input  wire logic [CW-1:0] step,
  input  wire gtg_in_t     in_data,
  input  wire logic [30:0] dist_thr,
  input  wire logic [13:0] orient_thr,
  input  wire logic [15:0] lin_gain,
  input  wire logic [15:0] head_gain,
  input  wire logic [15:0] orient_gain,
  output gtg_stat_t        stat,
  output gtg_out_t         out_data
);

  localparam int XW = 44;
  localparam int ZW = 28;
  localparam int WW = 31;
  localparam logic signed [WW-1:0] PI_W     = WW'(ANG_PI);
  localparam logic signed [WW-1:0] TWO_PI_W = WW'(ANG_2PI);

  logic               armed_r, latched_r;
  logic signed [31:0] tx_r, ty_r;
  logic signed [15:0] tyaw_r, yw_r;
  logic [31:0]        start_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic               zero_r;
  logic [63:0]        acc_r;
  logic [31:0]        dist_r;
  logic signed [WW-1:0] h_r, o_r;
  logic signed [31:0] pa_r, pb_r;
  logic [38:0]        rem_r;
  logic [31:0]        dvs_r;
  gtg_out_t           res_r;
  gtg_out_t           out_r;

  // Offset to goal, prescaled by 256.
  logic signed [32:0] dx, dy;
  logic signed [XW-1:0] dxs, dys;
  assign dx  = {tx_r[31], tx_r} - {in_data.pos_x[31], in_data.pos_x};
  assign dy  = {ty_r[31], ty_r} - {in_data.pos_y[31], in_data.pos_y};
  assign dxs = {{(XW-41){dx[32]}}, dx, 8'd0};
  assign dys = {{(XW-41){dy[32]}}, dy, 8'd0};

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  assign xs = x_r >>> step;
  assign ys = y_r >>> step;
  assign at = signed'({3'd0, atan_step(5'(step))});

  logic [42:0] mag;
  logic signed [ZW-1:0] bearing;
  assign mag     = zero_r ? '0 : x_r[42:0];
  assign bearing = zero_r ? '0 : z_r;

  // The magnitude is scaled by the inverse CORDIC gain in two partial products.
  logic [41:0] prod_lo;
  logic [40:0] prod_hi;
  assign prod_lo = mag[21:0] * KINV_Q20;
  assign prod_hi = mag[42:22] * KINV_Q20;

  logic signed [16:0] yaw_diff;
  assign yaw_diff = {tyaw_r[15], tyaw_r} - {yw_r[15], yw_r};

  logic [63:0] rnd;
  logic [35:0] d36;
  logic [31:0] dsat, thr;
  assign rnd  = acc_r + 64'd134217728;
  assign d36  = rnd[63:28];
  assign dsat = (d36[35:32] != 4'd0) ? 32'hFFFF_FFFF : d36[31:0];
  assign thr  = {1'b0, dist_thr};

  function automatic logic signed [WW-1:0] wrap_step(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v >= PI_W) r = v - TWO_PI_W;
    else if (v < -PI_W) r = v + TWO_PI_W;
    return r;
  endfunction

  logic signed [14:0] he, oe;
  logic [14:0] aoe;
  assign he  = h_r[26:12];
  assign oe  = o_r[26:12];
  assign aoe = oe[14] ? 15'(-oe) : 15'(oe);

  // Final decision terms.
  logic        below, above, reached;
  logic [31:0] num, start_eff;
  logic [47:0] lin_prod;
  logic [39:0] lin_sh;
  logic signed [32:0] ang_diff;
  logic signed [24:0] ang_sh;
  assign below     = dist_r < thr;
  assign above     = dist_r > thr;
  assign num       = dist_r - thr;
  assign start_eff = latched_r ? start_r : (above ? num : 32'd0);
  assign reached   = below && (aoe < {1'b0, orient_thr});
  assign lin_prod  = lin_gain * dist_r;
  assign lin_sh    = lin_prod[47:8];
  assign ang_diff  = 33'(pa_r) - 33'(pb_r);
  assign ang_sh    = 25'(ang_diff >>> 8);

  logic [31:0] sdiff;
  logic [38:0] sdiff100;
  assign sdiff    = start_eff - num;
  assign sdiff100 = {sdiff, 6'd0} + {2'd0, sdiff, 5'd0} + {5'd0, sdiff, 2'd0};

  logic [2:0]  shamt;
  logic [38:0] cmp;
  assign shamt = 3'(DIV_STEPS - 1) - 3'(step);
  assign cmp   = {7'd0, dvs_r} << shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      latched_r <= 1'b0;
      tx_r      <= '0;
      ty_r      <= '0;
      tyaw_r    <= '0;
      start_r   <= '0;
    end else begin
      if (cmd.goal_wr) begin
        tx_r      <= in_data.pos_x;
        ty_r      <= in_data.pos_y;
        tyaw_r    <= in_data.yaw;
        armed_r   <= 1'b1;
        latched_r <= 1'b0;
        start_r   <= '0;
      end
      if (cmd.fin) begin
        if (reached) begin
          armed_r   <= 1'b0;
          latched_r <= 1'b0;
          start_r   <= '0;
        end else begin
          latched_r <= 1'b1;
          start_r   <= start_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yw_r   <= in_data.yaw;
      zero_r <= (dx == 33'sd0) && (dy == 33'sd0);
      if (dx < 0) begin
        x_r <= -dxs;
        y_r <= -dys;
        z_r <= (dy >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
      end else begin
        x_r <= dxs;
        y_r <= dys;
        z_r <= '0;
      end
      res_r <= '{linear_velocity: '0, angular_velocity: '0, progress_percent: PROG_FULL,
                 goal_reached: 1'b0, goal_active: 1'b0};
    end
    if (cmd.rot) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
    if (cmd.mul0) begin
      acc_r <= {22'd0, prod_lo};
      h_r   <= WW'(bearing) - {{(WW-28){yw_r[15]}}, yw_r, 12'd0};
      o_r   <= {{(WW-29){yaw_diff[16]}}, yaw_diff, 12'd0};
    end
    if (cmd.mul1) acc_r <= acc_r + {1'b0, prod_hi, 22'd0};
    if (cmd.dist_ld) dist_r <= (dsat < thr) ? 32'd0 : dsat;
    if (cmd.wrap) begin
      h_r <= wrap_step(h_r);
      o_r <= wrap_step(o_r);
    end
    if (cmd.mula) pa_r <= signed'({1'b0, head_gain}) * he;
    if (cmd.mulb) pb_r <= signed'({1'b0, orient_gain}) * oe;
    if (cmd.fin) begin
      if (reached) begin
        res_r <= '{linear_velocity: '0, angular_velocity: '0, progress_percent: PROG_FULL,
                   goal_reached: 1'b1, goal_active: 1'b0};
      end else begin
        res_r.linear_velocity  <= (lin_sh[39:31] != 9'd0) ? 31'h7FFF_FFFF : lin_sh[30:0];
        res_r.angular_velocity <= 32'(ang_sh);
        res_r.goal_reached     <= 1'b0;
        res_r.goal_active      <= 1'b1;
        // Between start and goal the divider shifts the quotient in from zero.
        res_r.progress_percent <= (above && start_eff != 32'd0) ? '0 : PROG_FULL;
        rem_r <= sdiff100;
        dvs_r <= start_eff;
      end
    end
    if (cmd.div) begin
      if (rem_r >= cmp) begin
        rem_r <= rem_r - cmp;
        res_r.progress_percent <= {res_r.progress_percent[5:0], 1'b1};
      end else begin
        res_r.progress_percent <= {res_r.progress_percent[5:0], 1'b0};
      end
    end
    if (cmd.out_load) out_r <= res_r;
  end

  // Division runs only when the robot is between the start and the goal.
  assign stat.armed      = armed_r;
  assign stat.div_needed = !reached && above && (start_eff != 32'd0) && (num < start_eff);
  assign out_data        = out_r;

endmodule

`default_nettype wire

// ----- design/gtg_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtg_ctrl: sequencer of the go-to-goal controller
// Walks armed ticks via CORDIC, scaling, wrapping, gains and optional division.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_ctrl
  import gtg_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int CW = $clog2(CORDIC_STEPS)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire gtg_stat_t stat,
  output gtg_cmd_t       cmd,
  output logic [CW-1:0]  step
);

  gtg_state_t    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept, out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_TICK) st_nxt = stat.armed ? S_ROT : S_OUT;
      end
      S_ROT:  if (cnt_r == CW'(CORDIC_STEPS - 1)) st_nxt = S_MUL0;
      S_MUL0: st_nxt = S_MUL1;
      S_MUL1: st_nxt = S_DIST;
      S_DIST: st_nxt = S_WRAP;
      S_WRAP: if (cnt_r == CW'(WRAP_STEPS - 1)) st_nxt = S_MULA;
      S_MULA: st_nxt = S_MULB;
      S_MULB: st_nxt = S_FIN;
      S_FIN:  st_nxt = stat.div_needed ? S_DIV : S_OUT;
      S_DIV:  if (cnt_r == CW'(DIV_STEPS - 1)) st_nxt = S_OUT;
      S_OUT:  if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (st_r == S_IDLE);
    cmd.goal_wr  = accept && in_op == OP_GOAL;
    cmd.load     = accept && in_op == OP_TICK;
    cmd.rot      = (st_r == S_ROT);
    cmd.mul0     = (st_r == S_MUL0);
    cmd.mul1     = (st_r == S_MUL1);
    cmd.dist_ld  = (st_r == S_DIST);
    cmd.wrap     = (st_r == S_WRAP);
    cmd.mula     = (st_r == S_MULA);
    cmd.mulb     = (st_r == S_MULB);
    cmd.fin      = (st_r == S_FIN);
    cmd.div      = (st_r == S_DIV);
    cmd.out_load = (st_r == S_OUT) && out_free;
  end

  assign cnt_nxt       = (st_nxt == st_r) ? cnt_r + CW'(1) : '0;
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign step      = cnt_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_TICK && !stat.armed |=> st_r == S_OUT)
    else $error("idle tick did not go straight to output");
  a_goal_arms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == OP_GOAL |=> stat.armed)
    else $error("goal write did not arm the controller");
  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROT && cnt_r == CW'(CORDIC_STEPS - 1) |=> st_r == S_MUL0)
    else $error("CORDIC ran a wrong number of steps");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT && out_valid_r && !out_ready |=> st_r == S_OUT && out_valid_r)
    else $error("result overwrote an untaken beat");
`endif

endmodule

`default_nettype wire
